// File: rtl/core/lzwe_pkg.sv
// lzwe_pkg: transaction types and fixed constants of the lzw variable width encoder
// used by the front queue, the dictionary back end and the top level
package lzwe_pkg;

   // input transaction
   typedef struct packed {
      logic       mode;
      logic [7:0] symbol;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic [2:0] pad_bits;
   } rsp_type;

   // front queue status towards the back end
   typedef struct packed {
      logic       empty;
      logic       full;
      logic [1:0] count;
   } q_status_type;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic        MODE_DATA   = 1'b0;
   localparam logic        MODE_END    = 1'b1;
   localparam logic [31:0] HASH_MULT   = 32'h9E37_79B1;
   localparam int unsigned KEY_W       = 24;
   localparam int unsigned ACC_W       = 24;
   localparam int unsigned MAX_WIDTH   = 16;

endpackage

// File: rtl/core/lzwe_ram.sv
// lzwe_ram: generic single write port ram with registered read
// no dependencies
module lzwe_ram #(
   parameter int unsigned WIDTH = 37,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/lzwe_front.sv
// lzwe_front: two entry input queue that takes transactions and tags end of stream
// depends on lzwe_pkg
module lzwe_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lzwe_pkg::req_type      push_item,
   output logic                   full,
   input  logic                   pop,
   output lzwe_pkg::req_type      pop_item,
   output logic                   pop_is_end,
   output lzwe_pkg::q_status_type status
);

   lzwe_pkg::req_type entry_ff [lzwe_pkg::QUEUE_DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == 2'(lzwe_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != 2'd0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + 1'(do_push);
      rd_ptr_in = rd_ptr_ff + 1'(do_pop);
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // head of queue and its class
   assign pop_item     = entry_ff[rd_ptr_ff];
   assign pop_is_end   = (entry_ff[rd_ptr_ff].mode == lzwe_pkg::MODE_END);
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = full;
   assign status.count = count_ff;

endmodule

// File: rtl/core/lzwe_back.sv
// lzwe_back: hashed dictionary search and insert, code packing and result register
// depends on lzwe_pkg and lzwe_ram
module lzwe_back #(
   parameter int unsigned DICT_BITS  = 12,
   parameter int unsigned HASH_SLOTS = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lzwe_pkg::q_status_type q_status,
   input  lzwe_pkg::req_type      q_item,
   input  logic                   q_is_end,
   output logic                   q_pop,
   output logic                   clearing,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output lzwe_pkg::rsp_type      rsp_item
);

   localparam int unsigned SLOT_BITS = $clog2(HASH_SLOTS);
   localparam int unsigned ENTRY_W   = 1 + lzwe_pkg::KEY_W + DICT_BITS;
   localparam int unsigned CAP_INT   =
      (DICT_BITS + 1 > lzwe_pkg::MAX_WIDTH) ? lzwe_pkg::MAX_WIDTH : DICT_BITS + 1;
   localparam logic [4:0]  WIDTH_CAP = 5'(CAP_INT);
   localparam logic [16:0] DICT_SIZE = 17'(1 << DICT_BITS);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(HASH_SLOTS - 1);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_HASH  = 6'b000100,
      ST_READ  = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [15:0]         match_code_ff, match_code_in;
   logic                match_valid_ff, match_valid_in;
   logic [16:0]         next_code_ff, next_code_in;
   logic [4:0]          width_ff, width_in;
   logic [lzwe_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [lzwe_pkg::KEY_W-1:0] key_ff, key_in;
   logic [7:0]          sym_ff, sym_in;
   logic [SLOT_BITS-1:0] h_ff, h_in;
   logic [SLOT_BITS-1:0] probe_ff, probe_in;
   logic                final_ff, final_in;
   logic                out_valid_ff, out_valid_in;
   lzwe_pkg::rsp_type   out_ff, out_in;

   logic                 ram_we;
   logic [SLOT_BITS-1:0] ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [ENTRY_W-1:0]   ram_rdata;
   logic                 ent_valid;
   logic [lzwe_pkg::KEY_W-1:0] ent_key;
   logic [DICT_BITS-1:0] ent_code;
   logic [33:0]          hash_prod;
   logic                 out_free;
   logic                 do_push;
   logic                 do_insert;
   logic [lzwe_pkg::ACC_W-1:0] code_bits;
   logic [lzwe_pkg::ACC_W-1:0] rel_bits;
   logic [lzwe_pkg::ACC_W-1:0] fin_bits;
   logic [4:0]           cnt_less8;

   lzwe_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(HASH_SLOTS)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(h_ff),
      .rdata(ram_rdata)
   );

   assign ent_valid = ram_rdata[ENTRY_W-1];
   assign ent_key   = ram_rdata[ENTRY_W-2 -: lzwe_pkg::KEY_W];
   assign ent_code  = ram_rdata[DICT_BITS-1:0];

   // low slot bits of the multiplicative hash only need the low 17 bits
   assign hash_prod = 34'(key_ff[16:0]) * 34'(lzwe_pkg::HASH_MULT[16:0]);

   assign out_free  = !out_valid_ff || rsp_pop;
   assign code_bits = lzwe_pkg::ACC_W'(match_code_ff)
                      & ((lzwe_pkg::ACC_W'(1) << width_ff) - lzwe_pkg::ACC_W'(1));
   assign cnt_less8 = cnt_ff - 5'd8;
   assign rel_bits  = acc_ff >> cnt_less8;
   assign fin_bits  = acc_ff << (5'd8 - cnt_ff);

   // sequencer: pick up, hash, probe, insert, pack and release bytes
   always_comb begin
      state_in       = state_ff;
      match_code_in  = match_code_ff;
      match_valid_in = match_valid_ff;
      next_code_in   = next_code_ff;
      width_in       = width_ff;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      key_in         = key_ff;
      sym_in         = sym_ff;
      h_in           = h_ff;
      probe_in       = probe_ff;
      final_in       = final_ff;
      out_valid_in   = out_valid_ff && !rsp_pop;
      out_in         = out_ff;
      q_pop          = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = h_ff;
      ram_wdata      = '0;
      do_push        = 1'b0;
      do_insert      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            h_in   = h_ff + SLOT_BITS'(1);
            if (h_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               if (q_is_end) begin
                  if (match_valid_ff) begin
                     do_push  = 1'b1;
                     final_in = 1'b1;
                     state_in = ST_EMIT;
                  end
               end else if (!match_valid_ff) begin
                  match_code_in  = {8'd0, q_item.symbol};
                  match_valid_in = 1'b1;
               end else begin
                  key_in   = {match_code_ff, q_item.symbol};
                  sym_in   = q_item.symbol;
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            h_in     = hash_prod[SLOT_BITS-1:0];
            probe_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!ent_valid) begin
               do_push   = 1'b1;
               do_insert = (next_code_ff < DICT_SIZE);
            end else if (ent_key == key_ff) begin
               match_code_in = 16'(ent_code);
               state_in      = ST_IDLE;
            end else if (probe_ff == LAST_SLOT) begin
               // table full: emit without adding
               do_push = 1'b1;
            end else begin
               h_in     = h_ff + SLOT_BITS'(1);
               probe_in = probe_ff + SLOT_BITS'(1);
               state_in = ST_READ;
            end
            if (do_push) begin
               match_code_in = {8'd0, sym_ff};
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cnt_ff > 5'd8) begin
               if (out_free) begin
                  out_valid_in    = 1'b1;
                  out_in.out_byte = rel_bits[7:0];
                  out_in.last     = 1'b0;
                  out_in.pad_bits = 3'd0;
                  cnt_in          = cnt_less8;
                  acc_in          = acc_ff
                     & ((lzwe_pkg::ACC_W'(1) << cnt_less8) - lzwe_pkg::ACC_W'(1));
               end
            end else if (final_ff) begin
               if (out_free) begin
                  out_valid_in    = 1'b1;
                  out_in.out_byte = fin_bits[7:0];
                  out_in.last     = 1'b1;
                  out_in.pad_bits = 3'(5'd8 - cnt_ff);
                  // stream done: back to reset state, then sweep the table
                  match_code_in   = '0;
                  match_valid_in  = 1'b0;
                  next_code_in    = 17'd256;
                  width_in        = 5'd8;
                  acc_in          = '0;
                  cnt_in          = '0;
                  final_in        = 1'b0;
                  h_in            = '0;
                  state_in        = ST_CLEAR;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            h_in     = '0;
         end
      endcase

      // append the pending code at the current width
      if (do_push) begin
         acc_in = (acc_ff << width_ff) | code_bits;
         cnt_in = cnt_ff + width_ff;
      end

      // new dictionary entry, width grows after the code is sent
      if (do_insert) begin
         ram_we       = 1'b1;
         ram_wdata    = {1'b1, key_ff, next_code_ff[DICT_BITS-1:0]};
         next_code_in = next_code_ff + 17'd1;
         if ((next_code_ff >= ((17'd1 << width_ff) - 17'd1)) && (width_ff < WIDTH_CAP)) begin
            width_in = width_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         match_code_ff  <= '0;
         match_valid_ff <= 1'b0;
         next_code_ff   <= 17'd256;
         width_ff       <= 5'd8;
         acc_ff         <= '0;
         cnt_ff         <= '0;
         h_ff           <= '0;
         probe_ff       <= '0;
         final_ff       <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         match_code_ff  <= match_code_in;
         match_valid_ff <= match_valid_in;
         next_code_ff   <= next_code_in;
         width_ff       <= width_in;
         acc_ff         <= acc_in;
         cnt_ff         <= cnt_in;
         h_ff           <= h_in;
         probe_ff       <= probe_in;
         final_ff       <= final_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      sym_ff <= sym_in;
      out_ff <= out_in;
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

// File: rtl/core/lzw_variable_width_encoder.sv
// lzw_variable_width_encoder: top level, front input queue and dictionary back end
// depends on lzwe_pkg, lzwe_front, lzwe_back and lzwe_ram
//
// Byte-wise LZW encoder with growing code width, codes packed MSB first. A transaction
// is picked up from the two entry input queue in the idle state; the first byte of a
// stream and an end transaction with nothing pending finish there. Any other data byte
// passes a hash state and, per table probe, a ram read state and a check state (one ram
// read with registered data); the emit state then releases bytes, one per cycle while
// the receiver does not stall, through the single result register.
// After reset, and after every end of stream that carried data, the block sweeps the
// hash table before it takes the next item from its queue; the queue still accepts up
// to two transactions meanwhile.
module lzw_variable_width_encoder #(
   parameter int unsigned DICT_BITS  = 12,
   parameter int unsigned HASH_SLOTS = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  lzwe_pkg::req_type req_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output lzwe_pkg::rsp_type rsp_item
);

   lzwe_pkg::q_status_type q_status;
   lzwe_pkg::req_type      q_item;
   logic                   q_is_end;
   logic                   q_pop;
   logic                   clearing;

   lzwe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (req_item),
      .full      (req_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .pop_is_end(q_is_end),
      .status    (q_status)
   );

   lzwe_back #(
      .DICT_BITS (DICT_BITS),
      .HASH_SLOTS(HASH_SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_item   (q_item),
      .q_is_end (q_is_end),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_item (rsp_item)
   );

   // back end never takes from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

   // queue fill never exceeds its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= 2'(lzwe_pkg::QUEUE_DEPTH))
      else $error("queue overfilled");

   // no transaction taken during the table sweep
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("transaction taken while clearing");

endmodule

// File: sim/lzw_variable_width_encoder_tb.sv
// lzw_variable_width_encoder_tb: self-checking testbench for the lzw variable width encoder
// depends on lzwe_pkg and lzw_variable_width_encoder; queue driver, queue monitor, own lzw predictor
`timescale 1ns / 100ps

module lzw_variable_width_encoder_tb;

   localparam int unsigned DICT_BITS  = 12;
   localparam int unsigned HASH_SLOTS = 8192;
   localparam int unsigned WIDTH_CAP  = (DICT_BITS + 1 > 16) ? 16 : DICT_BITS + 1;
   localparam int unsigned LIMIT      = 2000000;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   lzwe_pkg::req_type req_item;
   logic              rsp_empty;
   logic              rsp_pop;
   lzwe_pkg::rsp_type rsp_item;

   lzw_variable_width_encoder #(
      .DICT_BITS(DICT_BITS),
      .HASH_SLOTS(HASH_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_item(req_item),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // predictor state: pending string, code allocation and bit packer
   logic [15:0] cur_prefix;
   logic        have_prefix;
   int unsigned next_free;
   int unsigned code_bits;
   logic [31:0] pack_acc;
   int unsigned pack_cnt;
   logic [24:0] dict_key [HASH_SLOTS];
   logic [15:0] dict_code [HASH_SLOTS];

   lzwe_pkg::req_type pending_items [$];
   lzwe_pkg::rsp_type expected_bytes [$];
   int unsigned mismatches;
   int unsigned cycles;
   logic        stim_done;
   logic        hold_sender;

   function automatic void clear_encoder();
      cur_prefix  = '0;
      have_prefix = 1'b0;
      next_free   = 256;
      code_bits   = 8;
      pack_acc    = '0;
      pack_cnt    = 0;
      for (int i = 0; i < HASH_SLOTS; i++) dict_key[i] = '0;
   endfunction

   function automatic void add_byte(logic [7:0] b, logic lst, logic [2:0] pad);
      lzwe_pkg::rsp_type r;
      r.out_byte = b;
      r.last     = lst;
      r.pad_bits = pad;
      expected_bytes.insert(expected_bytes.size(), r);
   endfunction

   // append a code MSB first, release bytes while more than 8 bits are held
   function automatic void pack_code(logic [15:0] code);
      pack_acc = (pack_acc << code_bits) | (32'(code) & ((32'd1 << code_bits) - 1));
      pack_cnt += code_bits;
      while (pack_cnt > 8) begin
         add_byte(8'(pack_acc >> (pack_cnt - 8)), 1'b0, 3'd0);
         pack_cnt -= 8;
         pack_acc &= (32'd1 << pack_cnt) - 1;
      end
   endfunction

   function automatic void encode_item(lzwe_pkg::req_type it);
      logic [23:0] key;
      logic [31:0] prod;
      int unsigned slot;
      int unsigned free_slot;
      logic        found_free;
      if (it.mode == lzwe_pkg::MODE_END) begin
         if (have_prefix) begin
            pack_code(cur_prefix);
            add_byte(8'(pack_acc << (8 - pack_cnt)), 1'b1, 3'(8 - pack_cnt));
         end
         clear_encoder();
         return;
      end
      if (!have_prefix) begin
         cur_prefix  = 16'(it.symbol);
         have_prefix = 1'b1;
         return;
      end
      key        = {cur_prefix, it.symbol};
      prod       = 32'(key) * lzwe_pkg::HASH_MULT;
      slot       = prod % HASH_SLOTS;
      found_free = 1'b0;
      free_slot  = 0;
      for (int n = 0; n < HASH_SLOTS; n++) begin
         if (!dict_key[slot][24]) begin
            free_slot  = slot;
            found_free = 1'b1;
            break;
         end
         if (dict_key[slot][23:0] == key) begin
            cur_prefix = dict_code[slot];
            return;
         end
         slot = (slot + 1) % HASH_SLOTS;
      end
      pack_code(cur_prefix);
      if (found_free && next_free < (1 << DICT_BITS)) begin
         dict_key[free_slot]  = {1'b1, key};
         dict_code[free_slot] = 16'(next_free);
         if (next_free >= (1 << code_bits) - 1 && code_bits < WIDTH_CAP) code_bits++;
         next_free++;
      end
      cur_prefix = 16'(it.symbol);
   endfunction

   // driver: bursts of pushes with random gaps
   int unsigned burst_left;
   int unsigned gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_push   <= 1'b0;
         req_item   <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_push && !req_full) begin
            encode_item(req_item);
            void'(pending_items.pop_front());
         end
         if (req_push && req_full) begin
            // hold the current transaction
         end else if (hold_sender || pending_items.size() == 0) begin
            req_push <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_push <= 1'b0;
         end else begin
            req_push <= 1'b1;
            req_item <= pending_items[0];
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 20);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // monitor: receiver stalls in its own pattern, compare each popped transaction
   int unsigned stall_phase;
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop     <= 1'b0;
         stall_phase <= 0;
         mismatches  <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected byte %h last %b pad %0d", rsp_item.out_byte,
                           rsp_item.last, rsp_item.pad_bits);
            end else begin
               if (rsp_item !== expected_bytes[0]) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: exp byte %h last %b pad %0d, got %h %b %0d",
                              expected_bytes[0].out_byte, expected_bytes[0].last,
                              expected_bytes[0].pad_bits, rsp_item.out_byte,
                              rsp_item.last, rsp_item.pad_bits);
               end
               void'(expected_bytes.pop_front());
            end
         end
         stall_phase <= (stall_phase + 1) % 37;
         if (stall_phase < 12) rsp_pop <= 1'b1;
         else if (stall_phase < 20) rsp_pop <= 1'b0;
         else rsp_pop <= ($urandom_range(0, 2) != 0);
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void queue_item(logic m, logic [7:0] s);
      lzwe_pkg::req_type it;
      it.mode   = m;
      it.symbol = s;
      pending_items.insert(pending_items.size(), it);
   endfunction

   // stimulus
   initial begin
      int unsigned count;
      int unsigned len;
      int unsigned alpha;
      cycles      = 0;
      stim_done   = 1'b0;
      hold_sender = 1'b0;
      req_push    = 1'b0;
      req_item    = '0;
      rsp_pop     = 1'b0;
      reset       = 1'b1;
      clear_encoder();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty stream, single byte, extremes, repeats
      queue_item(lzwe_pkg::MODE_END, 8'hff);
      queue_item(lzwe_pkg::MODE_DATA, 8'h00);
      queue_item(lzwe_pkg::MODE_END, 8'h00);
      queue_item(lzwe_pkg::MODE_DATA, 8'hff);
      queue_item(lzwe_pkg::MODE_DATA, 8'h00);
      queue_item(lzwe_pkg::MODE_DATA, 8'hff);
      queue_item(lzwe_pkg::MODE_DATA, 8'h00);
      queue_item(lzwe_pkg::MODE_DATA, 8'hff);
      queue_item(lzwe_pkg::MODE_DATA, 8'h00);
      queue_item(lzwe_pkg::MODE_END, 8'h55);
      for (int i = 0; i < 12; i++) queue_item(lzwe_pkg::MODE_DATA, 8'haa);
      queue_item(lzwe_pkg::MODE_END, 8'h00);

      // pause until the directed part has drained
      wait (pending_items.size() == 0);
      hold_sender = 1'b1;
      wait (expected_bytes.size() == 0);
      @(posedge clock);
      hold_sender <= 1'b0;

      // random streams of mixed entropy
      count = 0;
      while (count < 130) begin
         len   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(10, 120);
         alpha = $urandom_range(0, 3);
         for (int i = 0; i < len; i++) begin
            if (alpha == 0) queue_item(lzwe_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
            else queue_item(lzwe_pkg::MODE_DATA, 8'($urandom_range(0, alpha)) ^ 8'h5c);
         end
         queue_item(lzwe_pkg::MODE_END, 8'($urandom));
         count += len + 1;
      end
      // one long high-entropy stream, enough new codes to pass the 9 to 10 bit step
      for (int i = 0; i < 280; i++) queue_item(lzwe_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
      queue_item(lzwe_pkg::MODE_END, 8'h00);

      wait (pending_items.size() == 0);
      wait (expected_bytes.size() == 0);
      repeat (HASH_SLOTS + 200) @(posedge clock);
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/lzwe_pkg.sv
rtl/core/lzwe_ram.sv
rtl/core/lzwe_front.sv
rtl/core/lzwe_back.sv
rtl/core/lzw_variable_width_encoder.sv
sim/lzw_variable_width_encoder_tb.sv
